FILE: design/assert_macros.svh
// Assertion macros shared by the vertex dedup indexer modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define VDI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies another one in the same cycle.
`define VDI_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that a condition implies another one in the next cycle.
`define VDI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/vdi_pkg.sv
// Package for the vertex dedup indexer: table sizes, request and result
// types, controller/datapath interface structs and float compare helpers.
package vdi_pkg;

  localparam int TABLE_CAPACITY = 256;
  localparam int ADDR_W         = $clog2(TABLE_CAPACITY);
  localparam int CNT_W          = $clog2(TABLE_CAPACITY + 1);
  localparam int COORD_W        = 32;
  localparam int INDEX_W        = 8;
  localparam int ENTRY_W        = 3 * COORD_W;

  localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
  } vdi_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] vertex_index;
    logic               was_new;
    logic               table_full;
  } vdi_out_t;

  typedef enum logic [1:0] {
    RES_CLEAR = 2'd0,
    RES_HIT   = 2'd1,
    RES_NEW   = 2'd2,
    RES_FULL  = 2'd3
  } res_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      start;
    logic      clear;
    logic      search;
    logic      append;
    logic      set_res;
    res_kind_t res_kind;
    logic      load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic exhausted;
    logic full;
    logic out_free;
  } dp_stat_t;

  function automatic logic is_nan32(input logic [COORD_W-1:0] b);
    return b[COORD_W-2:0] > 31'h7F80_0000;
  endfunction

  // Float equality: signed zeros match, NaN matches nothing.
  function automatic logic float_eq(input logic [COORD_W-1:0] a,
                                    input logic [COORD_W-1:0] b);
    logic [COORD_W-1:0] ab;
    ab = a | b;
    return !is_nan32(a) && !is_nan32(b) &&
           ((ab[COORD_W-2:0] == '0) || (a == b));
  endfunction

  function automatic logic [INDEX_W-1:0] sat_index(input logic [CNT_W-1:0] i);
    return (i > CNT_W'(INDEX_MAX)) ? INDEX_MAX : INDEX_W'(i);
  endfunction

endpackage

FILE: design/vdi_ctrl.sv
// Controller state machine of the vertex dedup indexer.
// Depends on vdi_pkg for the command and status structs.
`include "assert_macros.svh"

module vdi_ctrl
  import vdi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_action,
  input  dp_stat_t stat,
  output logic     in_stall,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_APPEND = 4'b0100,
    ST_OUT    = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.res_kind = RES_CLEAR;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          if (in_action == ACT_CLEAR) begin
            cmd.clear    = 1'b1;
            cmd.set_res  = 1'b1;
            cmd.res_kind = RES_CLEAR;
            state_nxt    = ST_OUT;
          end else begin
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        priority if (stat.hit) begin
          cmd.set_res  = 1'b1;
          cmd.res_kind = RES_HIT;
          state_nxt    = ST_OUT;
        end else if (stat.exhausted && stat.full) begin
          cmd.set_res  = 1'b1;
          cmd.res_kind = RES_FULL;
          state_nxt    = ST_OUT;
        end else if (stat.exhausted) begin
          state_nxt = ST_APPEND;
        end else begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_APPEND: begin
        cmd.append   = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_kind = RES_NEW;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `VDI_ASSERT_NEXT(a_out_returns_idle, (state_r == ST_OUT) && stat.out_free, state_r == ST_IDLE, "result handed off but controller did not return to idle")
  `VDI_ASSERT_IMPLY(a_append_not_full, state_r == ST_APPEND, !stat.full, "append entered with a full table")
  `VDI_ASSERT(a_state_onehot, $onehot(state_r), "controller state is not one-hot")

endmodule

FILE: design/vdi_datapath.sv
// Datapath of the vertex dedup indexer: vertex table memory, search pointer,
// float compare, entry count and the result/output registers. Uses vdi_pkg.
`include "assert_macros.svh"

module vdi_datapath
  import vdi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  vdi_in_t  in_data,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  input  logic     out_stall,
  output logic     out_valid,
  output vdi_out_t out_data
);

  logic [ENTRY_W-1:0] mem [TABLE_CAPACITY];

  logic [COORD_W-1:0] vx_r, vy_r, vz_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic [ENTRY_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]  rd_idx_r;
  logic               rd_vld_r, rd_vld_nxt;
  logic               issue;
  logic               hit;
  vdi_out_t           res_r;
  vdi_out_t           out_r;
  logic               out_valid_r, out_valid_nxt;

  // Entries are packed as x in the top word, then y, then z.
  assign hit = rd_vld_r &&
               float_eq(rd_data_r[3*COORD_W-1:2*COORD_W], vx_r) &&
               float_eq(rd_data_r[2*COORD_W-1:COORD_W],   vy_r) &&
               float_eq(rd_data_r[COORD_W-1:0],           vz_r);

  assign issue      = cmd.search && (ptr_r < count_r) && !hit;
  assign ptr_nxt    = cmd.start ? '0 : (issue ? ptr_r + 1'b1 : ptr_r);
  assign rd_vld_nxt = issue;

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.append) begin
      count_nxt = count_r + 1'b1;
    end
  end

  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_valid_r && out_stall);

  assign stat.hit       = hit;
  assign stat.exhausted = !rd_vld_r && (ptr_r >= count_r);
  assign stat.full      = (count_r >= CNT_W'(TABLE_CAPACITY));
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Table port: one write for appends, one registered read for the search.
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[count_r[ADDR_W-1:0]] <= {vx_r, vy_r, vz_r};
    end
    if (issue) begin
      rd_data_r <= mem[ptr_r[ADDR_W-1:0]];
      rd_idx_r  <= ptr_r[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      vx_r <= in_data.coord_x;
      vy_r <= in_data.coord_y;
      vz_r <= in_data.coord_z;
    end
    if (cmd.set_res) begin
      unique case (cmd.res_kind)
        RES_CLEAR: res_r <= '{vertex_index: '0, was_new: 1'b0, table_full: 1'b0};
        RES_HIT:   res_r <= '{vertex_index: sat_index(CNT_W'(rd_idx_r)),
                              was_new: 1'b0, table_full: 1'b0};
        RES_NEW:   res_r <= '{vertex_index: sat_index(count_r),
                              was_new: 1'b1, table_full: 1'b0};
        RES_FULL:  res_r <= '{vertex_index: INDEX_MAX, was_new: 1'b0, table_full: 1'b1};
        default:   res_r <= res_r;
      endcase
    end
    if (cmd.load_out) begin
      out_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ptr_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `VDI_ASSERT(a_count_bound, count_r <= CNT_W'(TABLE_CAPACITY), "entry count exceeds table capacity")
  `VDI_ASSERT_IMPLY(a_hit_in_range, hit, CNT_W'(rd_idx_r) < count_r, "hit on an entry beyond the count")
  `VDI_ASSERT_IMPLY(a_load_when_free, cmd.load_out, stat.out_free, "output loaded over an unaccepted result")

endmodule

FILE: design/vertex_dedup_indexer.sv
// Vertex dedup indexer: one request at a time, each searched linearly.
// A clear request goes from idle straight to the output state. A lookup scans the stored
// entries in order through the single read port of the 256-entry table, stopping at the
// first hit; a miss then appends the vertex, or reports the table full. The next request
// is taken in the cycle after the result is handed off.
// Reset empties the table by zeroing the entry count; table contents are not swept.
module vertex_dedup_indexer
  import vdi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  vdi_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output vdi_out_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  vdi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .stat      (stat),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  vdi_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: tb/tb.sv
// Self-checking bench for vertex_dedup_indexer: directed vertices, a full-table fill,
// then random meshes, scored against a behavioral dedup predictor or fixed expected results.
// Depends on vdi_pkg and the vertex_dedup_indexer RTL.
module tb
  import vdi_pkg::*;
();

  localparam int LIMIT = 3_000_000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int HOLD_CYCLES = 3000;
  localparam int DIR_ROWS = 20;

  typedef struct packed {
    vdi_in_t  req;
    logic     typed;
    vdi_out_t want;
  } dir_row_t;

  // Rows with typed set carry their result; the others rely on the predictor.
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{'{ACT_CLEAR,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1, '{8'd0, 1'b0, 1'b0}},
    '{'{ACT_LOOKUP, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000}, 1'b1, '{8'd0, 1'b1, 1'b0}},
    '{'{ACT_LOOKUP, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000}, 1'b1, '{8'd0, 1'b0, 1'b0}},
    '{'{ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1, '{8'd1, 1'b1, 1'b0}},
    '{'{ACT_LOOKUP, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b1, '{8'd1, 1'b0, 1'b0}},
    '{'{ACT_LOOKUP, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000}, 1'b1, '{8'd1, 1'b0, 1'b0}},
    '{'{ACT_LOOKUP, 32'h7FC0_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1, '{8'd2, 1'b1, 1'b0}},
    '{'{ACT_LOOKUP, 32'h7FC0_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1, '{8'd3, 1'b1, 1'b0}},
    '{'{ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{8'd4, 1'b1, 1'b0}},
    '{'{ACT_LOOKUP, 32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF}, 1'b1, '{8'd5, 1'b1, 1'b0}},
    '{'{ACT_LOOKUP, 32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF}, 1'b1, '{8'd5, 1'b0, 1'b0}},
    '{'{ACT_LOOKUP, 32'h7F80_0001, 32'h0000_0000, 32'h0000_0000}, 1'b1, '{8'd6, 1'b1, 1'b0}},
    '{'{ACT_LOOKUP, 32'h0000_0001, 32'h8000_0001, 32'h0080_0000}, 1'b0, '0},
    '{'{ACT_LOOKUP, 32'h8000_0001, 32'h0000_0001, 32'h0080_0000}, 1'b0, '0},
    '{'{ACT_LOOKUP, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0001}, 1'b0, '0},
    '{'{ACT_LOOKUP, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000}, 1'b1, '{8'd0, 1'b0, 1'b0}},
    '{'{ACT_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{8'd0, 1'b0, 1'b0}},
    '{'{ACT_LOOKUP, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000}, 1'b1, '{8'd0, 1'b1, 1'b0}},
    '{'{ACT_LOOKUP, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F7F_FFFF}, 1'b1, '{8'd1, 1'b1, 1'b0}},
    '{'{ACT_CLEAR,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1, '{8'd0, 1'b0, 1'b0}}
  };

  localparam logic [COORD_W-1:0] ODD_COORDS [10] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
    32'hFFFF_FFFF, 32'h7F80_0001, 32'h0000_0001, 32'h3F80_0000, 32'h7F7F_FFFF
  };

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  vdi_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  vdi_out_t out_data;

  vertex_dedup_indexer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: the unique vertices of the current mesh.
  logic [ENTRY_W-1:0] mesh_vertices [TABLE_CAPACITY];
  int unsigned        mesh_count = 0;

  vdi_out_t    owed_results [$];
  int unsigned err_cnt = 0;
  int unsigned requests_sent = 0;
  int unsigned cycles = 0;
  bit          src_idle = 1'b1;
  bit          hold_go = 1'b0;
  logic        hold_on = 1'b0;

  function automatic bit coord_same(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
    // A NaN has an all-ones exponent and a nonzero fraction; it matches nothing.
    if ((a & 32'h7FFF_FFFF) > 32'h7F80_0000 || (b & 32'h7FFF_FFFF) > 32'h7F80_0000)
      return 1'b0;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
      return 1'b1;
    return a == b;
  endfunction

  function automatic vdi_out_t dedup_lookup(input vdi_in_t r);
    vdi_out_t res;
    res = '0;
    if (r.action == ACT_CLEAR) begin
      mesh_count = 0;
      return res;
    end
    for (int i = 0; i < mesh_count; i++) begin
      if (coord_same(mesh_vertices[i][95:64], r.coord_x) &&
          coord_same(mesh_vertices[i][63:32], r.coord_y) &&
          coord_same(mesh_vertices[i][31:0], r.coord_z)) begin
        res.vertex_index = (i > 255) ? INDEX_MAX : i[INDEX_W-1:0];
        return res;
      end
    end
    if (mesh_count >= TABLE_CAPACITY) begin
      res.vertex_index = INDEX_MAX;
      res.table_full   = 1'b1;
      return res;
    end
    mesh_vertices[mesh_count] = {r.coord_x, r.coord_y, r.coord_z};
    res.vertex_index = (mesh_count > 255) ? INDEX_MAX : mesh_count[INDEX_W-1:0];
    res.was_new      = 1'b1;
    mesh_count++;
    return res;
  endfunction

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10)
      $display("ERROR at cycle %0d: %s", cycles, msg);
  endtask

  task automatic push_request(input vdi_in_t r, input logic typed, input vdi_out_t want);
    int unsigned gap;
    vdi_out_t    pred;
    gap = src_idle ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    pred = dedup_lookup(r);
    owed_results.insert(owed_results.size(), typed ? want : pred);
    requests_sent++;
  endtask

  function automatic logic [COORD_W-1:0] pick_coord();
    if ($urandom_range(0, 4) == 0)
      return ODD_COORDS[$urandom_range(0, 9)];
    return $urandom;
  endfunction

  // Signed zeros must still match, so reused zero coordinates flip sign at random.
  function automatic logic [COORD_W-1:0] flip_zero(input logic [COORD_W-1:0] c);
    if (c[30:0] == 31'd0 && $urandom_range(0, 1) == 1)
      return {~c[31], c[30:0]};
    return c;
  endfunction

  task automatic run_mesh(input int unsigned n_items, input int unsigned pool_sz,
                          input bit in_order);
    logic [ENTRY_W-1:0] pool [$];
    logic [ENTRY_W-1:0] vtx;
    vdi_in_t            r;
    int unsigned        j;
    repeat (pool_sz) pool.insert(pool.size(), {pick_coord(), pick_coord(), pick_coord()});
    r = '{ACT_CLEAR, $urandom, $urandom, $urandom};
    push_request(r, 1'b1, '0);
    for (int k = 0; k < n_items; k++) begin
      j = (in_order && k < pool_sz) ? k : $urandom_range(0, pool_sz - 1);
      vtx = pool[j];
      if ($urandom_range(0, 19) == 0)
        vtx = {$urandom, $urandom, $urandom};
      r.action  = ($urandom_range(0, 99) == 0) ? ACT_CLEAR : ACT_LOOKUP;
      r.coord_x = flip_zero(vtx[95:64]);
      r.coord_y = flip_zero(vtx[63:32]);
      r.coord_z = flip_zero(vtx[31:0]);
      push_request(r, 1'b0, '0);
    end
  endtask

  // Long receiver hold-off, timed here so the sender keeps pushing meanwhile.
  initial begin : hold_off
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  initial begin : result_sink
    int unsigned wait_n;
    bit          calm;
    vdi_out_t    want;
    calm = 1'b0;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 29) == 0)
        calm = !calm;
      wait_n = calm ? 0 : $urandom_range(0, 13);
      if (wait_n != 0 || hold_on) begin
        out_stall <= 1'b1;
        while (wait_n != 0 || hold_on) begin
          @(posedge clk);
          if (wait_n != 0)
            wait_n--;
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (owed_results.size() == 0) begin
        note_error($sformatf("unexpected result idx=%0d new=%0b full=%0b",
                             out_data.vertex_index, out_data.was_new, out_data.table_full));
      end else begin
        want = owed_results.pop_front();
        if (out_data.vertex_index !== want.vertex_index || out_data.was_new !== want.was_new ||
            out_data.table_full !== want.table_full)
          note_error($sformatf("expected idx=%0d new=%0b full=%0b, got idx=%0d new=%0b full=%0b",
                               want.vertex_index, want.was_new, want.table_full,
                               out_data.vertex_index, out_data.was_new, out_data.table_full));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    vdi_in_t     r;
    int unsigned random_start;
    int unsigned mesh_no;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      push_request(DIR_TAB[i].req, DIR_TAB[i].typed, DIR_TAB[i].want);

    // Fill the table with distinct vertices, then miss on a full table.
    for (int i = 0; i < TABLE_CAPACITY; i++) begin
      r = '{ACT_LOOKUP, 32'h4000_0000 + i, 32'hC000_0000 ^ i, i};
      push_request(r, 1'b0, '0);
    end
    push_request('{ACT_LOOKUP, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F}, 1'b1,
                 '{INDEX_MAX, 1'b0, 1'b1});
    push_request('{ACT_LOOKUP, 32'h7FC0_0000, 32'h7FC0_0000, 32'h7FC0_0000}, 1'b1,
                 '{INDEX_MAX, 1'b0, 1'b1});
    push_request('{ACT_LOOKUP, 32'h4000_00FF, 32'hC000_00FF, 32'h0000_00FF}, 1'b0, '0);
    push_request('{ACT_LOOKUP, 32'h4000_0000, 32'hC000_0000, 32'h8000_0000}, 1'b0, '0);
    push_request('{ACT_CLEAR, 32'h0, 32'h0, 32'h0}, 1'b1, '{8'd0, 1'b0, 1'b0});

    random_start = requests_sent;
    mesh_no = 0;
    while (requests_sent - random_start < RANDOM_ITEMS) begin
      src_idle = ($urandom_range(0, 3) != 0);
      if (mesh_no == 2 || mesh_no == 9) begin
        run_mesh(330, 300, 1'b1);
      end else if (mesh_no == 6) begin
        src_idle = 1'b0;
        hold_go  = 1'b1;
        run_mesh(40, 12, 1'b0);
      end else begin
        run_mesh($urandom_range(4, 40), $urandom_range(1, 24), 1'b0);
      end
      mesh_no++;
    end
    in_valid <= 1'b0;

    while (owed_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (err_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/vdi_pkg.sv
design/vdi_ctrl.sv
design/vdi_datapath.sv
design/vertex_dedup_indexer.sv
tb/tb.sv
